### hdl/lclm_pkg.sv
// Shared types and codes for the LED command lease mirror.
// Used by lclm_record and led_command_lease_mirror; depends on nothing else.
`default_nettype none

package lclm_pkg;

  // Item kinds carried on the input tuser bit.
  typedef enum logic {
    CMD_OFFER = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  // Verdict on an offered command.
  typedef enum logic [2:0] {
    ACC_NEW      = 3'd0,
    ACC_REFRESH  = 3'd1,
    ACC_INVALID  = 3'd2,
    ACC_STALE    = 3'd3,
    ACC_CONFLICT = 3'd4
  } acc_code_t;

  // Pattern codes: 0 to 5 are real patterns, 6 reports a lost or expired lease.
  localparam logic [2:0] PAT_LAST = 3'd5;
  localparam logic [2:0] PAT_LOST = 3'd6;

  // Configuration register map (register index taken from paddr[2]).
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic        REG_LEASE_MIN = 1'b0;
  localparam logic        REG_LEASE_MAX = 1'b1;
  localparam logic [31:0] LEASE_MIN_RST = 32'd1;
  localparam logic [31:0] LEASE_MAX_RST = 32'hFFFF_FFFF;

  // Field widths.
  localparam int unsigned IN_DATA_W  = 136;
  localparam int unsigned OUT_DATA_W = 40;

  // One input word, unpacked.
  typedef struct packed {
    cmd_t        command;
    logic [2:0]  pattern;
    logic [31:0] generation;
    logic [31:0] lease_ms;
    logic [62:0] now_ms;
  } item_t;

  // One result word, unpacked.
  typedef struct packed {
    acc_code_t   accept_code;
    logic [2:0]  effective_pattern;
    logic [31:0] change_count;
  } result_t;

  // Record status seen by the top level.
  typedef struct packed {
    logic        has_record;
    logic [31:0] change_count;
  } status_t;

endpackage

`default_nettype wire

### hdl/lclm_record.sv
// Held command record and the decision logic for one offer or query word.
// Depends on lclm_pkg for the item, result and status types.
`default_nettype none

module lclm_record (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire lclm_pkg::item_t  item,
  input  wire logic [31:0]      lease_min,
  input  wire logic [31:0]      lease_max,
  output lclm_pkg::result_t     result,
  output lclm_pkg::status_t     status
);

  logic        has_r;
  logic [2:0]  pat_r;
  logic [31:0] gen_r;
  logic [31:0] lease_r;
  logic [62:0] time_r;
  logic [31:0] changes_r;

  logic        has_nxt;
  logic [2:0]  pat_nxt;
  logic [31:0] gen_nxt;
  logic [31:0] lease_nxt;
  logic [62:0] time_nxt;
  logic [31:0] changes_nxt;

  logic               fields_ok;
  logic               gen_older;
  logic               gen_same;
  logic               same_content;
  logic               time_back;
  logic [62:0]        age;
  logic               lease_live;
  logic [2:0]         held_eff;
  lclm_pkg::acc_code_t code;
  logic               store;

  // Compares against the lease bounds and the held record, all in parallel.
  assign fields_ok = (item.pattern <= lclm_pkg::PAT_LAST) && (item.generation != 32'd0) &&
                     (item.lease_ms >= lease_min) && (item.lease_ms <= lease_max);
  assign gen_older    = item.generation < gen_r;
  assign gen_same     = item.generation == gen_r;
  assign same_content = (item.pattern == pat_r) && (item.lease_ms == lease_r);
  assign time_back    = item.now_ms < time_r;
  assign age          = item.now_ms - time_r;
  assign lease_live   = age < {31'd0, lease_r};

  // Pattern in force when the held record is left untouched.
  assign held_eff = (!has_r || time_back || !lease_live) ? lclm_pkg::PAT_LOST : pat_r;

  // Verdict on an offer; queries always report the new-code value.
  always_comb begin
    code  = lclm_pkg::ACC_NEW;
    store = 1'b0;
    if (item.command == lclm_pkg::CMD_OFFER) begin
      if (!fields_ok) begin
        code = lclm_pkg::ACC_INVALID;
      end else if (!has_r) begin
        code  = lclm_pkg::ACC_NEW;
        store = 1'b1;
      end else if (gen_older) begin
        code = lclm_pkg::ACC_STALE;
      end else if (gen_same) begin
        if (!same_content) begin
          code = lclm_pkg::ACC_CONFLICT;
        end else if (time_back) begin
          code = lclm_pkg::ACC_INVALID;
        end else begin
          code  = lclm_pkg::ACC_REFRESH;
          store = 1'b1;
        end
      end else if (time_back) begin
        code = lclm_pkg::ACC_INVALID;
      end else begin
        code  = lclm_pkg::ACC_NEW;
        store = 1'b1;
      end
    end
  end

  // Next record. A refresh carries the held pattern and lease, so writing the
  // item's fields is the same as keeping them.
  always_comb begin
    has_nxt     = has_r;
    pat_nxt     = pat_r;
    gen_nxt     = gen_r;
    lease_nxt   = lease_r;
    time_nxt    = time_r;
    changes_nxt = changes_r;
    if (step && store) begin
      has_nxt   = 1'b1;
      pat_nxt   = item.pattern;
      gen_nxt   = item.generation;
      lease_nxt = item.lease_ms;
      time_nxt  = item.now_ms;
      if (!has_r) begin
        changes_nxt = 32'd1;
      end else if (code == lclm_pkg::ACC_NEW && item.pattern != pat_r) begin
        changes_nxt = changes_r + 32'd1;
      end
    end
  end

  // Record registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_r     <= 1'b0;
      pat_r     <= 3'd0;
      gen_r     <= 32'd0;
      lease_r   <= 32'd0;
      time_r    <= 63'd0;
      changes_r <= 32'd0;
    end else begin
      has_r     <= has_nxt;
      pat_r     <= pat_nxt;
      gen_r     <= gen_nxt;
      lease_r   <= lease_nxt;
      time_r    <= time_nxt;
      changes_r <= changes_nxt;
    end
  end

  // A stored command starts its lease at now, so it is live unless the lease is zero.
  always_comb begin
    result.accept_code = code;
    if (store) begin
      result.effective_pattern = (item.lease_ms != 32'd0) ? item.pattern : lclm_pkg::PAT_LOST;
    end else begin
      result.effective_pattern = held_eff;
    end
    result.change_count = changes_nxt;
  end

  assign status.has_record   = has_r;
  assign status.change_count = changes_r;

endmodule

`default_nettype wire

### hdl/led_command_lease_mirror.sv
// LED command lease mirror, top level: stream ports, configuration registers,
// input and result registers. Depends on lclm_pkg and lclm_record.
//
// Usage. Offer and query words arrive on the in_ stream; in_tuser selects an
// offer (0) or a query (1). Each word yields exactly one result word on the
// out_ stream: the verdict on the offer, the pattern in force at the word's
// time and the running count of pattern changes.
// A word accepted at one clock edge is captured in the input register, then
// judged against the held record; the result is loaded into the result register
// once that register is empty or being read out, which raises out_tvalid. One
// word per cycle is sustained while out_tready stays high: the record update and
// the verdict are one pass of compares and one 63-bit subtraction between the
// two registers. When the receiver stalls, the result register holds its word,
// the input register holds the next word, and in_tready falls once both are full.
// The lease bounds must be written through the APB-style port only while the
// stream is idle; the block does not enforce this. Reset clears the record, the
// change count and both stream valid flags, and sets the bounds to 1 and 0xFFFFFFFF.
`default_nettype none

module led_command_lease_mirror (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [2:0] cmd_pattern, [34:3] cmd_generation, [66:35] cmd_lease_ms,
  // [129:67] now_ms, [135:130] zero
  input  wire logic [lclm_pkg::IN_DATA_W-1:0]      in_tdata,
  // [0] command
  input  wire logic                                in_tuser,
  // Result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [2:0] accept_code, [5:3] effective_pattern, [37:6] change_count, [39:38] zero
  output logic [lclm_pkg::OUT_DATA_W-1:0]          out_tdata,
  // Configuration port
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [lclm_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [31:0]                         cfg_pwdata,
  output logic [31:0]                              cfg_prdata,
  output logic                                     cfg_pready
);

  logic                rd_sel;
  logic [31:0]         lease_min_val_r;
  logic [31:0]         lease_max_val_r;
  logic                cfg_write;

  logic                in_fire;
  logic                a_valid_r;
  lclm_pkg::item_t     a_item_r;
  logic                step;
  logic                b_valid_r;
  lclm_pkg::result_t   b_res_r;
  lclm_pkg::item_t     in_item;
  lclm_pkg::result_t   res;
  lclm_pkg::status_t   stat;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lease_min_val_r <= lclm_pkg::LEASE_MIN_RST;
      lease_max_val_r <= lclm_pkg::LEASE_MAX_RST;
    end else if (cfg_write) begin
      unique case (cfg_paddr[2])
        lclm_pkg::REG_LEASE_MIN: lease_min_val_r <= cfg_pwdata;
        lclm_pkg::REG_LEASE_MAX: lease_max_val_r <= cfg_pwdata;
        default:                 lease_min_val_r <= lease_min_val_r;
      endcase
    end
  end

  // Read-back multiplexer
  assign rd_sel = cfg_paddr[2];
  always_comb begin
    unique case (rd_sel)
      lclm_pkg::REG_LEASE_MIN: cfg_prdata = lease_min_val_r;
      lclm_pkg::REG_LEASE_MAX: cfg_prdata = lease_max_val_r;
      default:                 cfg_prdata = 32'd0;
    endcase
  end

  // Unpack the input word.
  assign in_item.command    = lclm_pkg::cmd_t'(in_tuser);
  assign in_item.pattern    = in_tdata[2:0];
  assign in_item.generation = in_tdata[34:3];
  assign in_item.lease_ms   = in_tdata[66:35];
  assign in_item.now_ms     = in_tdata[129:67];

  // Pipeline flow: the input register moves on when the result register is
  // empty or being read out.
  assign step      = a_valid_r && (!b_valid_r || out_tready);
  assign in_tready = !a_valid_r || step;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_item_r <= in_item;
    end
  end

  // Decision logic and held record
  lclm_record u_record (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (a_item_r),
    .lease_min (lease_min_val_r),
    .lease_max (lease_max_val_r),
    .result    (res),
    .status    (stat)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (step) begin
      b_valid_r <= 1'b1;
    end else if (out_tready) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      b_res_r <= res;
    end
  end

  assign out_tvalid = b_valid_r;
  assign out_tdata  = {2'b00, b_res_r.change_count, b_res_r.effective_pattern,
                       b_res_r.accept_code};

  // Checks
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !step |=> a_valid_r && $stable(a_item_r))
    else $error("input register changed while stalled");

  a_record_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    stat.has_record |=> stat.has_record)
    else $error("held record was dropped");

  a_count_on_new_only: assert property (@(posedge clk) disable iff (!rst_n)
    step && (res.accept_code != lclm_pkg::ACC_NEW) |=> $stable(stat.change_count))
    else $error("change count moved without a new command");

  a_query_code: assert property (@(posedge clk) disable iff (!rst_n)
    step && (a_item_r.command == lclm_pkg::CMD_QUERY) |-> res.accept_code == lclm_pkg::ACC_NEW)
    else $error("query word carried a rejection code");

endmodule

`default_nettype wire
